// ===== src/tpl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared types, constants and coefficient ROM for the thermistor polynomial
// linearizer: fixed-point widths, channel words and Horner step helpers.
// ----------------------------------------------------------------------------
package tpl_pkg;

  // Channel field widths
  localparam int X_W       = 18;   // sample, unsigned Q2.16 volts
  localparam int X_FRAC    = 16;
  localparam int TEMP_W    = 32;   // signed Q16.16
  localparam int RES_W     = 32;   // unsigned Q24.8
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;

  // Register map
  localparam logic [CFG_ADDR_W-1:0] REG_TEMP_LOW  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_TEMP_HIGH = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_RES_LOW   = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_RES_HIGH  = CFG_ADDR_W'(3);

  // Valid span of the polynomial fit: 0.98 V .. 2.82 V in Q2.16
  localparam logic [X_W-1:0] SPAN_LOW_FIRST = X_W'(64226);
  localparam logic [X_W-1:0] SPAN_HIGH_LAST = X_W'(184811);

  // Accumulator: signed Q56.48, handled as four 26-bit limbs in the multiply
  localparam int COEF_FRAC = 48;
  localparam int ACC_W     = 104;
  localparam int LIMB_W    = 26;
  localparam int N_LIMBS   = ACC_W / LIMB_W;
  localparam int PP_W      = LIMB_W + X_W + 1;   // one limb times the sample
  localparam int SUM_W     = PP_W + LIMB_W + 1;  // two adjacent limb products
  localparam int PROD_W    = ACC_W + X_FRAC;     // full product kept before shift

  // Output rounding points
  localparam int T_LSB = COEF_FRAC - 16;
  localparam int R_LSB = COEF_FRAC - 8;

  // Polynomial sizes
  localparam int TEMP_TERMS   = 8;
  localparam int RES_TERMS    = 17;
  localparam int TEMP_ROM_LEN = 8;
  localparam int RES_ROM_LEN  = 17;
  localparam int TEMP_IDX_W   = (TEMP_ROM_LEN > 1) ? $clog2(TEMP_ROM_LEN) : 1;
  localparam int RES_IDX_W    = (RES_ROM_LEN > 1) ? $clog2(RES_ROM_LEN) : 1;

  // One cell per Horner step of the longer polynomial; the shorter one sees
  // leading zero coefficients, which keep its accumulator at zero.
  localparam int N_CELLS   = (TEMP_TERMS > RES_TERMS) ? TEMP_TERMS : RES_TERMS;
  localparam int STEP_MAXA = (N_CELLS > RES_ROM_LEN) ? N_CELLS : RES_ROM_LEN;
  localparam int STEP_SPAN = (STEP_MAXA > TEMP_ROM_LEN) ? STEP_MAXA : TEMP_ROM_LEN;
  localparam int STEP_W    = (STEP_SPAN > 1) ? $clog2(STEP_SPAN) : 1;

  localparam logic [63:0] DEC_ONE = 64'd1000000000000000000;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [PP_W-1:0]  pp_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef enum logic [1:0] {
    SPAN_IN    = 2'd0,
    SPAN_BELOW = 2'd1,
    SPAN_ABOVE = 2'd2
  } span_t;

  // Word handed from cell to cell
  typedef struct packed {
    logic [X_W-1:0] x;
    span_t          span;
    acc_t           acc_temp;
    acc_t           acc_res;
  } cell_word_t;

  // Limit registers
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_low;
    logic signed [TEMP_W-1:0] temp_high;
    logic [RES_W-1:0]         res_low;
    logic [RES_W-1:0]         res_high;
  } limits_t;

  localparam limits_t LIMITS_RST = '{
    temp_low:  -32'sd2621440,
    temp_high: 32'sd8192000,
    res_low:   32'd0,
    res_high:  32'd256000000
  };

  // Decimal coefficient (integer part, 18 fraction digits) to Q.48, rounded
  // half up on magnitude. Used only to build the constant ROMs below.
  function automatic acc_t coef_fixed(input logic neg, input logic [63:0] ip,
                                      input logic [63:0] fr);
    logic [63:0]      f;
    logic [63:0]      bits;
    logic [63:0]      ipv;
    logic [ACC_W-1:0] mag;
    f    = fr;
    bits = '0;
    ipv  = ip;
    for (int k = 0; k < COEF_FRAC; k++) begin
      f    = f << 1;
      bits = bits << 1;
      if (f >= DEC_ONE) begin
        bits = bits | 64'd1;
        f    = f - DEC_ONE;
      end
    end
    f = f << 1;
    if (f >= DEC_ONE) begin
      bits = bits + 64'd1;
    end
    if (bits[COEF_FRAC]) begin
      ipv             = ipv + 64'd1;
      bits[COEF_FRAC] = 1'b0;
    end
    mag = {ipv[ACC_W-COEF_FRAC-1:0], bits[COEF_FRAC-1:0]};
    return neg ? acc_t'(-mag) : acc_t'(mag);
  endfunction

  // Temperature fit, degree 7
  localparam acc_t TEMP_ROM [TEMP_ROM_LEN] = '{
    coef_fixed(1'b0, 64'd5434,  64'd232117314088100101),
    coef_fixed(1'b1, 64'd20169, 64'd466246021467668470),
    coef_fixed(1'b0, 64'd32463, 64'd933111048056161962),
    coef_fixed(1'b1, 64'd28938, 64'd226799701478739734),
    coef_fixed(1'b0, 64'd15353, 64'd409347028060437878),
    coef_fixed(1'b1, 64'd4841,  64'd37714594773206044),
    coef_fixed(1'b0, 64'd839,   64'd510375889344686584),
    coef_fixed(1'b1, 64'd61,    64'd781542503544187638)
  };

  // Resistance fit, degree 16
  localparam acc_t RES_ROM [RES_ROM_LEN] = '{
    coef_fixed(1'b0, 64'd2632885515,  64'd135468006134033203),
    coef_fixed(1'b1, 64'd17311600570, 64'd389953613281250000),
    coef_fixed(1'b0, 64'd47184509415, 64'd495796203613281250),
    coef_fixed(1'b1, 64'd63846048453, 64'd618972778320312500),
    coef_fixed(1'b0, 64'd30425587321, 64'd680206298828125000),
    coef_fixed(1'b0, 64'd32478530833, 64'd112487792968750000),
    coef_fixed(1'b1, 64'd55239679692, 64'd875663757324218750),
    coef_fixed(1'b0, 64'd12613996299, 64'd498186111450195312),
    coef_fixed(1'b0, 64'd45302555776, 64'd647583007812500000),
    coef_fixed(1'b1, 64'd65979595200, 64'd796844482421875000),
    coef_fixed(1'b0, 64'd49283512285, 64'd732421875000000),
    coef_fixed(1'b1, 64'd23980911162, 64'd897621154785156250),
    coef_fixed(1'b0, 64'd8027982169,  64'd407816886901855468),
    coef_fixed(1'b1, 64'd1848415946,  64'd544223785400390625),
    coef_fixed(1'b0, 64'd281176298,   64'd883506834506988525),
    coef_fixed(1'b1, 64'd25534498,    64'd307311791926622390),
    coef_fixed(1'b0, 64'd1050791,     64'd210161465452983975)
  };

  // Coefficient of a Horner step; zero past the term count or the ROM
  function automatic acc_t temp_coef(input logic [STEP_W-1:0] i);
    acc_t c;
    c = '0;
    if (int'(i) < TEMP_TERMS && int'(i) < TEMP_ROM_LEN) begin
      c = TEMP_ROM[i[TEMP_IDX_W-1:0]];
    end
    return c;
  endfunction

  function automatic acc_t res_coef(input logic [STEP_W-1:0] i);
    acc_t c;
    c = '0;
    if (int'(i) < RES_TERMS && int'(i) < RES_ROM_LEN) begin
      c = RES_ROM[i[RES_IDX_W-1:0]];
    end
    return c;
  endfunction

  // One accumulator limb times the sample; the top limb carries the sign
  function automatic pp_t limb_mul(input acc_t a, input logic [X_W-1:0] x,
                                   input int j);
    logic [LIMB_W-1:0]   limb;
    logic signed [LIMB_W:0] a_s;
    logic signed [X_W:0] x_s;
    pp_t                 p;
    limb = a[j*LIMB_W +: LIMB_W];
    a_s  = (j == N_LIMBS - 1) ? {limb[LIMB_W-1], limb} : {1'b0, limb};
    x_s  = {1'b0, x};
    p    = a_s * x_s;
    return p;
  endfunction

  // Two adjacent limb products folded into one partial sum
  function automatic sum_t pair_sum(input pp_t lo, input pp_t hi);
    sum_t a;
    sum_t b;
    a = lo;
    b = hi;
    return a + (b <<< LIMB_W);
  endfunction

  // floor(acc * x / 2^16) + c, wrapping in the accumulator width
  function automatic acc_t horner_fold(input sum_t lo, input sum_t hi, input acc_t c);
    logic signed [PROD_W-1:0] l;
    logic signed [PROD_W-1:0] h;
    logic signed [PROD_W-1:0] p;
    l = lo;
    h = hi;
    p = (h <<< (2 * LIMB_W)) + l;
    return acc_t'(p[PROD_W-1:X_FRAC] + c);
  endfunction

endpackage

// ===== src/tpl_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_in_if
// Sample channel: one voltage sample per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpl_in_if;
  logic                      valid;
  logic                      ready;
  logic [tpl_pkg::X_W-1:0]   sample_volts;

  modport source (output valid, output sample_volts, input ready);
  modport sink   (input valid, input sample_volts, output ready);
endinterface

// ===== src/tpl_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_out_if
// Result channel: temperature, resistance and span flag per word.
// ----------------------------------------------------------------------------
interface tpl_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tpl_pkg::TEMP_W-1:0] temperature;
  logic [tpl_pkg::RES_W-1:0]        resistance;
  logic                             out_of_span;

  modport source (output valid, output temperature, output resistance,
                  output out_of_span, input ready);
  modport sink   (input valid, input temperature, input resistance,
                  input out_of_span, output ready);
endinterface

// ===== src/tpl_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_cfg_if
// Register write channel: register index and write data per word.
// ----------------------------------------------------------------------------
interface tpl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tpl_pkg::CFG_ADDR_W-1:0]   addr;
  logic [tpl_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== src/tpl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_cell
// One Horner step for both polynomials, in three registered stages: limb
// multiplies, pair sums, then fold, shift and coefficient add.
// ----------------------------------------------------------------------------
module tpl_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [tpl_pkg::STEP_W-1:0]   step_idx,
  input  logic                         in_v,
  input  tpl_pkg::cell_word_t          in_d,
  output logic                         out_v,
  output tpl_pkg::cell_word_t          out_d
);

  tpl_pkg::pp_t  pt_nxt [tpl_pkg::N_LIMBS];
  tpl_pkg::pp_t  pr_nxt [tpl_pkg::N_LIMBS];

  logic                        s1_v_r;
  logic [tpl_pkg::X_W-1:0]     s1_x_r;
  tpl_pkg::span_t              s1_span_r;
  tpl_pkg::pp_t                s1_pt_r [tpl_pkg::N_LIMBS];
  tpl_pkg::pp_t                s1_pr_r [tpl_pkg::N_LIMBS];

  logic                        s2_v_r;
  logic [tpl_pkg::X_W-1:0]     s2_x_r;
  tpl_pkg::span_t              s2_span_r;
  tpl_pkg::sum_t               s2_tlo_r;
  tpl_pkg::sum_t               s2_thi_r;
  tpl_pkg::sum_t               s2_rlo_r;
  tpl_pkg::sum_t               s2_rhi_r;

  logic                        out_v_r;
  tpl_pkg::cell_word_t         out_d_r;
  tpl_pkg::cell_word_t         out_d_nxt;

  // limb products, one small multiplier per limb and lane
  always_comb begin
    for (int j = 0; j < tpl_pkg::N_LIMBS; j++) begin
      pt_nxt[j] = tpl_pkg::limb_mul(in_d.acc_temp, in_d.x, j);
      pr_nxt[j] = tpl_pkg::limb_mul(in_d.acc_res, in_d.x, j);
    end
  end

  // fold, drop 16 fraction bits, add this step's coefficient
  always_comb begin
    out_d_nxt.x        = s2_x_r;
    out_d_nxt.span     = s2_span_r;
    out_d_nxt.acc_temp = tpl_pkg::horner_fold(s2_tlo_r, s2_thi_r,
                                              tpl_pkg::temp_coef(step_idx));
    out_d_nxt.acc_res  = tpl_pkg::horner_fold(s2_rlo_r, s2_rhi_r,
                                              tpl_pkg::res_coef(step_idx));
  end

  // stage registers; the whole row freezes while en is low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_v;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
    if (en) begin
      s1_x_r    <= in_d.x;
      s1_span_r <= in_d.span;
      for (int j = 0; j < tpl_pkg::N_LIMBS; j++) begin
        s1_pt_r[j] <= pt_nxt[j];
        s1_pr_r[j] <= pr_nxt[j];
      end
      s2_x_r    <= s1_x_r;
      s2_span_r <= s1_span_r;
      s2_tlo_r  <= tpl_pkg::pair_sum(s1_pt_r[0], s1_pt_r[1]);
      s2_thi_r  <= tpl_pkg::pair_sum(s1_pt_r[2], s1_pt_r[3]);
      s2_rlo_r  <= tpl_pkg::pair_sum(s1_pr_r[0], s1_pr_r[1]);
      s2_rhi_r  <= tpl_pkg::pair_sum(s1_pr_r[2], s1_pr_r[3]);
      out_d_r   <= out_d_nxt;
    end
  end

  assign out_v = out_v_r;
  assign out_d = out_d_r;

endmodule

// ===== src/tpl_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_out
// Converts the final accumulators to the output formats, applies the span
// limits and holds results in a two-word output buffer.
// ----------------------------------------------------------------------------
module tpl_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tail_v,
  input  tpl_pkg::cell_word_t   tail_d,
  input  tpl_pkg::limits_t      limits,
  output logic                  en,
  tpl_out_if.source             out_bus
);

  typedef struct packed {
    logic signed [tpl_pkg::TEMP_W-1:0] temperature;
    logic [tpl_pkg::RES_W-1:0]         resistance;
    logic                              out_of_span;
  } res_word_t;

  localparam int T_TOP = tpl_pkg::T_LSB + tpl_pkg::TEMP_W;
  localparam int R_TOP = tpl_pkg::R_LSB + tpl_pkg::RES_W;

  tpl_pkg::acc_t  t_sum;
  tpl_pkg::acc_t  r_sum;
  logic           t_fits;
  logic           r_fits;
  logic signed [tpl_pkg::TEMP_W-1:0] t_val;
  logic [tpl_pkg::RES_W-1:0]         r_val;
  res_word_t      conv;

  logic           main_v_r;
  logic           skid_v_r;
  res_word_t      main_r;
  res_word_t      skid_r;
  logic           pop;
  logic           arrive;

  // round half up, then saturate to the field
  always_comb begin
    t_sum  = tail_d.acc_temp + (tpl_pkg::acc_t'(1) <<< (tpl_pkg::T_LSB - 1));
    t_fits = (&t_sum[tpl_pkg::ACC_W-1:T_TOP-1]) || !(|t_sum[tpl_pkg::ACC_W-1:T_TOP-1]);
    if (t_fits) begin
      t_val = t_sum[T_TOP-1:tpl_pkg::T_LSB];
    end else if (t_sum[tpl_pkg::ACC_W-1]) begin
      t_val = {1'b1, {(tpl_pkg::TEMP_W-1){1'b0}}};
    end else begin
      t_val = {1'b0, {(tpl_pkg::TEMP_W-1){1'b1}}};
    end

    r_sum  = tail_d.acc_res + (tpl_pkg::acc_t'(1) <<< (tpl_pkg::R_LSB - 1));
    r_fits = !(|r_sum[tpl_pkg::ACC_W-1:R_TOP]);
    if (tail_d.acc_res[tpl_pkg::ACC_W-1]) begin
      r_val = '0;
    end else if (r_fits) begin
      r_val = r_sum[R_TOP-1:tpl_pkg::R_LSB];
    end else begin
      r_val = '1;
    end
  end

  // limits replace the fit outside the span
  always_comb begin
    unique case (tail_d.span)
      tpl_pkg::SPAN_BELOW: begin
        conv.temperature = limits.temp_high;
        conv.resistance  = limits.res_low;
        conv.out_of_span = 1'b1;
      end
      tpl_pkg::SPAN_ABOVE: begin
        conv.temperature = limits.temp_low;
        conv.resistance  = limits.res_high;
        conv.out_of_span = 1'b1;
      end
      default: begin
        conv.temperature = t_val;
        conv.resistance  = r_val;
        conv.out_of_span = 1'b0;
      end
    endcase
  end

  // main register plus skid word; the chain runs while the skid is empty
  assign en     = !skid_v_r;
  assign pop    = main_v_r && out_bus.ready;
  assign arrive = tail_v && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!main_v_r || pop) begin
      main_v_r <= arrive;
    end else if (arrive) begin
      skid_v_r <= 1'b1;
    end

    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (!main_v_r || pop) begin
      main_r <= conv;
    end else if (arrive) begin
      skid_r <= conv;
    end
  end

  assign out_bus.valid       = main_v_r;
  assign out_bus.temperature = main_r.temperature;
  assign out_bus.resistance  = main_r.resistance;
  assign out_bus.out_of_span = main_r.out_of_span;

endmodule

// ===== src/thermistor_poly_linearizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_poly_linearizer_unit
// Voltage sample to temperature and resistance by two fixed regression
// polynomials, evaluated by Horner's rule in a chain of pipelined cells.
// ----------------------------------------------------------------------------
// Takes one sample word per clock while the chain is not held and returns one
// result word per sample, in order. Each of the 17 cells does one Horner
// step of both polynomials over three registered stages, so a sample passes
// the 3 x 17 cell stages and then the output register. The sustained rate is
// one word per clock while the output side keeps up, set by the cell chain.
// When the output side stalls, a two-word output buffer absorbs the chain's
// next word and in_bus.ready drops once that word sits in the skid register;
// the whole chain then holds until the skid word moves on. Samples below
// 0.98 V or above 2.82 V give the limit registers and out_of_span set. Limit
// registers are written on cfg_bus (index 0..3, others ignored), always ready;
// the user must write them only while no word is in flight, as the block
// itself does not enforce this.
module thermistor_poly_linearizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  tpl_in_if.sink     in_bus,
  tpl_out_if.source  out_bus,
  tpl_cfg_if.sink    cfg_bus
);

  logic                    en;
  logic                    chain_v [tpl_pkg::N_CELLS+1];
  tpl_pkg::cell_word_t     chain_d [tpl_pkg::N_CELLS+1];
  tpl_pkg::limits_t        limits_r;
  tpl_pkg::span_t          in_span;

  // limit registers
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r <= tpl_pkg::LIMITS_RST;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      unique case (cfg_bus.addr)
        tpl_pkg::REG_TEMP_LOW:  limits_r.temp_low  <= cfg_bus.wdata;
        tpl_pkg::REG_TEMP_HIGH: limits_r.temp_high <= cfg_bus.wdata;
        tpl_pkg::REG_RES_LOW:   limits_r.res_low   <= cfg_bus.wdata;
        tpl_pkg::REG_RES_HIGH:  limits_r.res_high  <= cfg_bus.wdata;
        default: ;
      endcase
    end
  end

  // span check on entry; accumulators start at zero
  always_comb begin
    if (in_bus.sample_volts < tpl_pkg::SPAN_LOW_FIRST) begin
      in_span = tpl_pkg::SPAN_BELOW;
    end else if (in_bus.sample_volts > tpl_pkg::SPAN_HIGH_LAST) begin
      in_span = tpl_pkg::SPAN_ABOVE;
    end else begin
      in_span = tpl_pkg::SPAN_IN;
    end
  end

  assign in_bus.ready        = en;
  assign chain_v[0]          = in_bus.valid;
  assign chain_d[0].x        = in_bus.sample_volts;
  assign chain_d[0].span     = in_span;
  assign chain_d[0].acc_temp = '0;
  assign chain_d[0].acc_res  = '0;

  // cell k runs Horner step N_CELLS-1-k, highest coefficient first
  for (genvar k = 0; k < tpl_pkg::N_CELLS; k++) begin : g_cell
    tpl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .step_idx (tpl_pkg::STEP_W'(tpl_pkg::N_CELLS - 1 - k)),
      .in_v     (chain_v[k]),
      .in_d     (chain_d[k]),
      .out_v    (chain_v[k+1]),
      .out_d    (chain_d[k+1])
    );
  end

  tpl_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .tail_v  (chain_v[tpl_pkg::N_CELLS]),
    .tail_d  (chain_d[tpl_pkg::N_CELLS]),
    .limits  (limits_r),
    .en      (en),
    .out_bus (out_bus)
  );

  // input stalls only with both output words occupied
  a_stall_needs_full_out : assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid)
    else $error("input stalled with output register empty");

  // a frozen chain keeps its last word unchanged
  a_chain_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(chain_v[tpl_pkg::N_CELLS]) && $stable(chain_d[tpl_pkg::N_CELLS]))
    else $error("cell chain moved while stalled");

  // ready drops only after a refused output word
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_bus.ready) |-> $past(out_bus.valid && !out_bus.ready))
    else $error("input stall without output back-pressure");

endmodule

// ===== verif/tpl_reading_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpl_reading_checker
// Watches the sample, result and register channels of the linearizer. It
// tracks the limit registers, computes the temperature and resistance that
// each accepted sample should give, and compares every result word in order.
// ----------------------------------------------------------------------------
module tpl_reading_checker (
  input  logic clk,
  input  logic rst_n,
  tpl_in_if    in_mon,
  tpl_out_if   out_mon,
  tpl_cfg_if   cfg_mon,
  output int   mismatches,
  output int   pending_words
);
  import tpl_pkg::*;

  typedef logic signed [127:0] q48_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [RES_W-1:0]         resistance;
    logic                     out_of_span;
  } reading_t;

  localparam int          N_TEMP_COEF = 8;
  localparam int          N_RES_COEF  = 17;
  localparam logic [127:0] DEC_SCALE  = 128'd1000000000000000000;

  q48_t     temp_coef [N_TEMP_COEF];
  q48_t     res_coef  [N_RES_COEF];
  limits_t  limits;
  reading_t expected_readings [$];
  int       words_checked;

  // Decimal coefficient (18 fraction digits) to Q.48, magnitude rounded half up
  function automatic q48_t dec_to_q48(input bit neg, input logic [63:0] whole,
                                      input logic [63:0] frac18);
    logic [127:0] scaled;
    logic [127:0] mag;
    scaled = ({64'd0, frac18} << 49) / DEC_SCALE;
    mag    = ({64'd0, whole} << 48) + ((scaled + 128'd1) >> 1);
    return neg ? q48_t'(-mag) : q48_t'(mag);
  endfunction

  initial begin
    temp_coef[0]  = dec_to_q48(1'b0, 64'd5434,        64'd232117314088100101);
    temp_coef[1]  = dec_to_q48(1'b1, 64'd20169,       64'd466246021467668470);
    temp_coef[2]  = dec_to_q48(1'b0, 64'd32463,       64'd933111048056161962);
    temp_coef[3]  = dec_to_q48(1'b1, 64'd28938,       64'd226799701478739734);
    temp_coef[4]  = dec_to_q48(1'b0, 64'd15353,       64'd409347028060437878);
    temp_coef[5]  = dec_to_q48(1'b1, 64'd4841,        64'd37714594773206044);
    temp_coef[6]  = dec_to_q48(1'b0, 64'd839,         64'd510375889344686584);
    temp_coef[7]  = dec_to_q48(1'b1, 64'd61,          64'd781542503544187638);
    res_coef[0]   = dec_to_q48(1'b0, 64'd2632885515,  64'd135468006134033203);
    res_coef[1]   = dec_to_q48(1'b1, 64'd17311600570, 64'd389953613281250000);
    res_coef[2]   = dec_to_q48(1'b0, 64'd47184509415, 64'd495796203613281250);
    res_coef[3]   = dec_to_q48(1'b1, 64'd63846048453, 64'd618972778320312500);
    res_coef[4]   = dec_to_q48(1'b0, 64'd30425587321, 64'd680206298828125000);
    res_coef[5]   = dec_to_q48(1'b0, 64'd32478530833, 64'd112487792968750000);
    res_coef[6]   = dec_to_q48(1'b1, 64'd55239679692, 64'd875663757324218750);
    res_coef[7]   = dec_to_q48(1'b0, 64'd12613996299, 64'd498186111450195312);
    res_coef[8]   = dec_to_q48(1'b0, 64'd45302555776, 64'd647583007812500000);
    res_coef[9]   = dec_to_q48(1'b1, 64'd65979595200, 64'd796844482421875000);
    res_coef[10]  = dec_to_q48(1'b0, 64'd49283512285, 64'd732421875000000);
    res_coef[11]  = dec_to_q48(1'b1, 64'd23980911162, 64'd897621154785156250);
    res_coef[12]  = dec_to_q48(1'b0, 64'd8027982169,  64'd407816886901855468);
    res_coef[13]  = dec_to_q48(1'b1, 64'd1848415946,  64'd544223785400390625);
    res_coef[14]  = dec_to_q48(1'b0, 64'd281176298,   64'd883506834506988525);
    res_coef[15]  = dec_to_q48(1'b1, 64'd25534498,    64'd307311791926622390);
    res_coef[16]  = dec_to_q48(1'b0, 64'd1050791,     64'd210161465452983975);
  end

  // acc * x / 2^16 rounded toward minus infinity, plus c, modulo 2^128
  function automatic q48_t horner_step(input q48_t acc, input logic [X_W-1:0] x,
                                       input q48_t c);
    logic signed [147:0] wide_acc;
    logic signed [147:0] wide_x;
    logic signed [147:0] prod;
    wide_acc = acc;
    wide_x   = {130'd0, x};
    prod     = wide_acc * wide_x;
    return q48_t'(prod[143:16]) + c;
  endfunction

  // Q.48 to Q16.16, half up, saturated
  function automatic logic signed [TEMP_W-1:0] round_temperature(input q48_t acc);
    q48_t s;
    q48_t q;
    s = acc + q48_t'(128'h8000_0000);
    q = s >>> 32;
    if ((&q[127:31]) || !(|q[127:31])) begin
      return q[31:0];
    end
    return s[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // Q.48 to Q24.8, zero when negative, half up, saturated at the top
  function automatic logic [RES_W-1:0] round_resistance(input q48_t acc);
    q48_t s;
    if (acc < 0) begin
      return '0;
    end
    s = acc + q48_t'(128'h80_0000_0000);
    if (s[127:72] == '0) begin
      return s[71:40];
    end
    return 32'hFFFF_FFFF;
  endfunction

  function automatic reading_t predict_reading(input logic [X_W-1:0] x);
    reading_t r;
    q48_t     acc_temp;
    q48_t     acc_res;
    if (x < SPAN_LOW_FIRST) begin
      r = '{temperature: limits.temp_high, resistance: limits.res_low, out_of_span: 1'b1};
    end else if (x > SPAN_HIGH_LAST) begin
      r = '{temperature: limits.temp_low, resistance: limits.res_high, out_of_span: 1'b1};
    end else begin
      acc_temp = '0;
      acc_res  = '0;
      for (int i = N_TEMP_COEF - 1; i >= 0; i--) begin
        acc_temp = horner_step(acc_temp, x, temp_coef[i]);
      end
      for (int i = N_RES_COEF - 1; i >= 0; i--) begin
        acc_res = horner_step(acc_res, x, res_coef[i]);
      end
      r = '{temperature: round_temperature(acc_temp), resistance: round_resistance(acc_res),
            out_of_span: 1'b0};
    end
    return r;
  endfunction

  // Channel monitor: register writes, sample words in, result words out
  always @(posedge clk) begin
    reading_t want;
    reading_t got;
    if (!rst_n) begin
      limits = LIMITS_RST;
      expected_readings.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.addr)
          REG_TEMP_LOW:  limits.temp_low  = cfg_mon.wdata;
          REG_TEMP_HIGH: limits.temp_high = cfg_mon.wdata;
          REG_RES_LOW:   limits.res_low   = cfg_mon.wdata;
          REG_RES_HIGH:  limits.res_high  = cfg_mon.wdata;
          default: ;  // unmapped index, no effect
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        expected_readings.push_back(predict_reading(in_mon.sample_volts));
      end

      if (out_mon.valid && out_mon.ready) begin
        got = '{temperature: out_mon.temperature, resistance: out_mon.resistance,
                out_of_span: out_mon.out_of_span};
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result word with nothing expected: temp %0d res %0d span %0b",
                     $realtime, got.temperature, got.resistance, got.out_of_span);
          end
        end else begin
          want = expected_readings.pop_front();
          if (got.temperature !== want.temperature || got.resistance !== want.resistance ||
              got.out_of_span !== want.out_of_span) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] word %0d mismatch: temp exp %0d got %0d, res exp %0d got %0d,",
                       $realtime, words_checked, want.temperature, got.temperature,
                       want.resistance, got.resistance);
              $display("    out_of_span exp %0b got %0b", want.out_of_span, got.out_of_span);
            end
          end
        end
        words_checked++;
      end
    end
    pending_words = expected_readings.size();
  end

endmodule

// ===== verif/thermistor_poly_linearizer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_poly_linearizer_unit_tb
// Drives voltage samples and limit register writes into the linearizer under
// bursty input traffic and a stalling result side, with a long output stall
// that backs up the pipeline. Checking is done by tpl_reading_checker.
// ----------------------------------------------------------------------------
module thermistor_poly_linearizer_unit_tb;
  import tpl_pkg::*;

  localparam int              CYCLE_LIMIT  = 200000;
  localparam int              HOLD_CYCLES  = 400;
  localparam int              SETTLE       = 64;   // well past the pipeline latency
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = CFG_ADDR_W'(4);

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_HEAVY
  } rx_mode_t;

  logic     clk;
  logic     rst_n;
  int       mismatches;
  int       pending_words;
  int       samples_sent;
  int       in_span_sent;
  int       reg_writes;
  int       limit_settings;
  int       hold_reqs;
  int       hold_served;
  int       hold_left;
  int       rx_tick;
  rx_mode_t rx_mode;

  tpl_in_if  in_bus ();
  tpl_out_if out_bus ();
  tpl_cfg_if cfg_bus ();

  thermistor_poly_linearizer_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  tpl_reading_checker checker_inst (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_mon       (cfg_bus),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Known values on every input from time zero
  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.sample_volts  = '0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.addr         = '0;
    cfg_bus.wdata        = '0;
    rx_mode              = RX_ALWAYS;
    hold_reqs            = 0;
    hold_served          = 0;
    hold_left            = 0;
    rx_tick              = 0;
  end

  // Result side: long hold-off on request, otherwise the current stall pattern
  initial begin
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        hold_left   = HOLD_CYCLES;
      end
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_bus.ready <= 1'b1;
          RX_RANDOM:  out_bus.ready <= ($urandom_range(3) != 0);
          RX_PATTERN: out_bus.ready <= ((rx_tick % 11) < 7);
          default:    out_bus.ready <= ($urandom_range(9) < 3);
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // One sample word; valid is left high for the caller to keep or drop
  task automatic send_sample(input logic [X_W-1:0] v);
    in_bus.sample_volts <= v;
    in_bus.valid        <= 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    samples_sent++;
    if (v >= SPAN_LOW_FIRST && v <= SPAN_HIGH_LAST) in_span_sent++;
  endtask

  task automatic end_traffic();
    in_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_bus.addr  <= idx;
    cfg_bus.wdata <= d;
    cfg_bus.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  task automatic set_limits(input logic [31:0] t_low, input logic [31:0] t_high,
                            input logic [31:0] r_low, input logic [31:0] r_high);
    cfg_write(REG_TEMP_LOW, t_low);
    cfg_write(REG_TEMP_HIGH, t_high);
    cfg_write(REG_RES_LOW, r_low);
    cfg_write(REG_RES_HIGH, r_high);
    limit_settings++;
  endtask

  // Wait until every result word is back, then let the pipeline settle
  task automatic wait_drained();
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly inside the fit span, some near its edges, the rest outside
  function automatic logic [X_W-1:0] random_sample();
    int pick;
    int base;
    pick = $urandom_range(99);
    if (pick < 55) begin
      return X_W'($urandom_range(int'(SPAN_HIGH_LAST), int'(SPAN_LOW_FIRST)));
    end else if (pick < 65) begin
      base = $urandom_range(1) ? int'(SPAN_LOW_FIRST) : int'(SPAN_HIGH_LAST);
      return X_W'(base + int'($urandom_range(16)) - 8);
    end else if (pick < 80) begin
      return X_W'($urandom_range(int'(SPAN_LOW_FIRST) - 1));
    end
    return X_W'($urandom_range(262143, int'(SPAN_HIGH_LAST) + 1));
  endfunction

  // Bursts of random length; max_gap of zero keeps valid high throughout
  task automatic run_traffic(input int n_items, input int max_gap);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(40, 1);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_sample(random_sample());
        sent++;
      end
      if (max_gap > 0 && $urandom_range(3) != 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(max_gap, 1)) @(negedge clk);
      end
    end
    end_traffic();
  endtask

  // Stimulus
  initial begin
    logic [X_W-1:0] edge_samples [14];
    edge_samples = '{18'd0, 18'd1, 18'd64225, 18'd64226, 18'd64227, 18'd100000,
                     18'h15555, 18'h20000, 18'h2AAAA, 18'd184810, 18'd184811,
                     18'd184812, 18'h3FFFE, 18'h3FFFF};
    samples_sent   = 0;
    in_span_sent   = 0;
    reg_writes     = 0;
    limit_settings = 1;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Span edges and field extremes with the reset limits
    rx_mode = RX_RANDOM;
    foreach (edge_samples[i]) send_sample(edge_samples[i]);
    end_traffic();
    wait_drained();

    // Extreme limits, plus writes to unmapped indexes that must change nothing
    set_limits(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    cfg_write(REG_UNMAPPED, $urandom);
    cfg_write(CFG_ADDR_W'($urandom_range(255, 5)), $urandom);
    send_sample(18'd0);
    send_sample(18'd64225);
    send_sample(18'd184812);
    send_sample(18'h3FFFF);
    send_sample(18'd131071);
    end_traffic();

    // Long result stall while samples keep coming: pipeline fills, input stalls
    rx_mode = RX_ALWAYS;
    hold_reqs++;
    run_traffic(160, 0);
    wait_drained();

    rx_mode = RX_RANDOM;
    run_traffic(220, 12);
    wait_drained();

    // Opposite extremes
    set_limits(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    rx_mode = RX_PATTERN;
    run_traffic(220, 6);
    wait_drained();

    // Random limits under heavy result stalls
    set_limits($urandom, $urandom, $urandom, $urandom);
    rx_mode = RX_HEAVY;
    run_traffic(220, 15);
    wait_drained();

    // Back to the power-on limits, no idling on either side
    set_limits(LIMITS_RST.temp_low, LIMITS_RST.temp_high, LIMITS_RST.res_low,
               LIMITS_RST.res_high);
    rx_mode = RX_ALWAYS;
    run_traffic(130, 0);
    wait_drained();

    $display("Covered %0d samples, %0d inside the fit span and %0d clipped to limits,",
             samples_sent, in_span_sent, samples_sent - in_span_sent);
    $display("over %0d limit settings with %0d register writes and one long output stall.",
             limit_settings, reg_writes);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
